// ----- rtl/apq_pkg.sv -----
`default_nettype none
package apq_pkg;

    typedef enum logic {
        ACT_ENQUEUE = 1'b0,
        ACT_DEQUEUE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_REMOVED   = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/apq_cell.sv -----
`default_nettype none
module apq_cell (
    input  wire logic          aclk,
    input  wire apq_pkg::cmd_t cmd_i,
    input  wire logic          occ_i,
    input  wire logic          left_ge_i,
    input  wire apq_pkg::entry_t left_entry_i,
    input  wire apq_pkg::entry_t right_entry_i,
    output logic               ge_o,
    output apq_pkg::entry_t    entry_o
);

    apq_pkg::entry_t entry_reg;
    apq_pkg::entry_t entry_next;

    // occupied and at least as urgent as the incoming request: stays ahead of it
    assign ge_o    = occ_i && (entry_reg.prio >= cmd_i.item.prio);
    assign entry_o = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd_i.enq) begin
            if (!ge_o) begin
                // first cell behind the insertion point takes the new entry, the rest shift
                entry_next = left_ge_i ? cmd_i.item : left_entry_i;
            end
        end else if (cmd_i.deq) begin
            entry_next = right_entry_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ----- rtl/array_priority_queue_unit.sv -----
// Bounded priority queue of DEPTH entries, each a signed 32-bit value with a
// signed 16-bit priority. Requests arrive on the s_ channel: s_tuser selects
// enqueue or dequeue, s_tdata carries value and priority (ignored on dequeue).
// Every request yields exactly one result on the m_ channel: m_tuser is the
// status (added, overflow, removed, underflow), m_tdata the removed entry (zero
// unless removed) and the occupancy after the request.
// Entries sit in a chain of cells kept sorted by priority, earlier entries
// ahead on a tie. An enqueue broadcasts the new entry; each cell compares it
// with its own and either holds, takes it, or takes its left neighbour's entry.
// A dequeue shifts the whole chain towards the head and reports the head cell.
// A result is registered and appears in the cycle after its request is taken;
// the per-cell compare lets one request in every cycle while m_tready is high.
// A finished result waits in the output register while the receiver stalls;
// s_tready then stays low until it is taken, so nothing is lost.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are left as they are and are never read unoccupied.
`default_nettype none
module array_priority_queue_unit #(
    parameter int DEPTH = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [31:0] removed_value, [47:32] removed_priority,
                                        // [55:48] occupancy
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    apq_pkg::status_t    status_reg;
    apq_pkg::status_t    status_next;
    apq_pkg::entry_t     removed_reg;
    apq_pkg::entry_t     removed_next;
    logic [7:0]          occ_reg;
    logic [7:0]          occ_next;

    logic                accept;
    logic                is_deq;
    logic                full;
    logic                empty;
    logic [31:0]         count_ext;
    apq_pkg::cmd_t       cmd;
    apq_pkg::entry_t     cell_entry [DEPTH];
    logic                cell_ge    [DEPTH];
    logic                cell_occ   [DEPTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser[0] == apq_pkg::ACT_DEQUEUE);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.item.value = s_tdata[31:0];
    assign cmd.item.prio  = s_tdata[47:32];
    assign cmd.enq        = accept && !is_deq && !full;
    assign cmd.deq        = accept && is_deq && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            apq_pkg::entry_t left_entry;
            apq_pkg::entry_t right_entry;
            logic            left_ge;

            assign cell_occ[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_head
                assign left_ge    = 1'b1;
                assign left_entry = cmd.item;
            end else begin : g_body
                assign left_ge    = cell_ge[gi-1];
                assign left_entry = cell_entry[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_entry = cell_entry[gi];
            end else begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            apq_cell u_cell (
                .aclk          (aclk),
                .cmd_i         (cmd),
                .occ_i         (cell_occ[gi]),
                .left_ge_i     (left_ge),
                .left_entry_i  (left_entry),
                .right_entry_i (right_entry),
                .ge_o          (cell_ge[gi]),
                .entry_o       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        occ_next     = occ_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            removed_next = '0;
            if (cmd.enq) begin
                count_next  = count_reg + CNT_W'(1);
                status_next = apq_pkg::ST_ADDED;
            end else if (cmd.deq) begin
                count_next   = count_reg - CNT_W'(1);
                status_next  = apq_pkg::ST_REMOVED;
                removed_next = cell_entry[0];
            end else if (is_deq) begin
                status_next = apq_pkg::ST_UNDERFLOW;
            end else begin
                status_next = apq_pkg::ST_OVERFLOW;
            end
            occ_next = count_ext[7:0];
        end
    end

    assign count_ext = 32'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg  <= status_next;
        removed_reg <= removed_next;
        occ_reg     <= occ_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {occ_reg, removed_reg.prio, removed_reg.value};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_enq_added: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.enq |=> m_valid_reg && (status_reg == apq_pkg::ST_ADDED)
                    && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("enqueue request not reported as added");

    a_deq_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq |=> (status_reg == apq_pkg::ST_REMOVED)
                    && (removed_reg == $past(cell_entry[0]))
                    && (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not report head cell");

    a_zero_unless_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (status_reg != apq_pkg::ST_REMOVED) |-> (removed_reg == '0))
        else $error("removed fields not zero");

    a_head_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > CNT_W'(1)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("chain head out of priority order");

endmodule
`default_nettype wire
